/* hdl/bsk_pkg.sv */
// Shared constants and types of the Biot-Savart kernel pipeline.
// Used by every module of the block; depends on nothing.
package bsk_pkg;

  localparam int NORM_BITS  = 24;
  localparam int E_W        = 8;
  localparam int SH_W       = 10;
  localparam int M_W        = 24;
  localparam int S_W        = 50;
  localparam int Q_W        = 16;
  localparam int R_W        = 32;
  localparam int T_W        = 32;
  localparam int K_W        = 30;
  localparam int P_W        = 64;
  localparam int X_W        = 64;
  localparam int ROOT_STEPS = 32;
  localparam int DIV1_STEPS = 16;
  localparam int DIV2_STEPS = 32;
  localparam int DIV1_PRE   = 22;
  localparam int DIV2_PRE   = 14;
  localparam int SQRT_PRE   = 14;

  localparam logic [K_W-1:0] K_TWO_PI_INV  = 30'd683565276;
  localparam logic [K_W-1:0] K_FOUR_PI_INV = 30'd341782638;

  typedef struct packed {
    logic                   valid;
    logic                   mode;
    logic [2:0]             neg;
    logic                   zero;
    logic signed [SH_W-1:0] sh;
  } side_t;

  typedef logic [2:0][M_W-1:0] norm3_t;
  typedef logic [2:0][Q_W-1:0] quot3_t;
  typedef logic [2:0][T_W-1:0] tq3_t;

endpackage

/* hdl/bsk_front.sv */
// Front pipeline: difference vector, magnitudes, normalization, squares and sum.
// Depends on bsk_pkg.
module bsk_front #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic                          mode,
  input  logic signed [COORD_WIDTH-1:0] eval_x,
  input  logic signed [COORD_WIDTH-1:0] eval_y,
  input  logic signed [COORD_WIDTH-1:0] eval_z,
  input  logic signed [COORD_WIDTH-1:0] source_x,
  input  logic signed [COORD_WIDTH-1:0] source_y,
  input  logic signed [COORD_WIDTH-1:0] source_z,
  output bsk_pkg::side_t                side_o,
  output bsk_pkg::norm3_t               norm_o,
  output logic [bsk_pkg::S_W-1:0]       sum_o
);

  localparam int DW = COORD_WIDTH + 1;

  bsk_pkg::side_t side1_nxt, side2_nxt, side3_nxt, side4_nxt, side5_nxt;
  bsk_pkg::side_t side1_r, side2_r, side3_r, side4_r, side5_r, side6_r, side7_r;

  logic signed [DW-1:0] diff1_r [3];
  logic [DW-1:0] mag2_r [3];
  logic [DW-1:0] mag3_r [3];
  logic [DW-1:0] mag4_r [3];
  logic [DW-1:0] max3_nxt, max3_r;
  logic signed [bsk_pkg::E_W-1:0] exp4_nxt, exp4_r;
  bsk_pkg::norm3_t norm5_nxt, norm5_r, norm6_r, norm7_r;
  logic [2*bsk_pkg::M_W-1:0] sq6_r [3];
  logic [bsk_pkg::S_W-1:0] sum7_r;

  always_comb begin
    side1_nxt = '0;
    side1_nxt.valid = in_valid;
    side1_nxt.mode = mode;
  end

  always_comb begin
    side2_nxt = side1_r;
    for (int i = 0; i < 3; i++) begin
      side2_nxt.neg[i] = diff1_r[i][DW-1] && (i < 2 || side1_r.mode);
    end
  end

  always_comb begin
    side3_nxt = side2_r;
    max3_nxt = mag2_r[0];
    if (mag2_r[1] > max3_nxt) begin
      max3_nxt = mag2_r[1];
    end
    if (mag2_r[2] > max3_nxt) begin
      max3_nxt = mag2_r[2];
    end
  end

  always_comb begin
    int len;
    len = 0;
    for (int i = 0; i < DW; i++) begin
      if (max3_r[i]) begin
        len = i + 1;
      end
    end
    exp4_nxt = bsk_pkg::E_W'(len - bsk_pkg::NORM_BITS);
    side4_nxt = side3_r;
    side4_nxt.zero = (max3_r == '0);
  end

  always_comb begin
    logic [bsk_pkg::E_W-1:0] rsh;
    logic [bsk_pkg::E_W-1:0] lsh;
    rsh = exp4_r;
    lsh = bsk_pkg::E_W'(-exp4_r);
    for (int i = 0; i < 3; i++) begin
      if (exp4_r > 0) begin
        norm5_nxt[i] = bsk_pkg::M_W'(bsk_pkg::X_W'(mag4_r[i]) >> rsh);
      end else begin
        norm5_nxt[i] = bsk_pkg::M_W'(bsk_pkg::X_W'(mag4_r[i]) << lsh);
      end
    end
    side5_nxt = side4_r;
    if (side4_r.mode) begin
      side5_nxt.sh = bsk_pkg::SH_W'(3 * FRAC_BITS - 109 - 2 * int'(exp4_r));
    end else begin
      side5_nxt.sh = bsk_pkg::SH_W'(2 * FRAC_BITS - 70 - int'(exp4_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side1_r <= '0;
      side2_r <= '0;
      side3_r <= '0;
      side4_r <= '0;
      side5_r <= '0;
      side6_r <= '0;
      side7_r <= '0;
    end else if (en) begin
      side1_r <= side1_nxt;
      side2_r <= side2_nxt;
      side3_r <= side3_nxt;
      side4_r <= side4_nxt;
      side5_r <= side5_nxt;
      side6_r <= side5_r;
      side7_r <= side6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff1_r[0] <= DW'(eval_x) - DW'(source_x);
      diff1_r[1] <= DW'(eval_y) - DW'(source_y);
      diff1_r[2] <= DW'(eval_z) - DW'(source_z);
      for (int i = 0; i < 3; i++) begin
        if (i == 2 && !side1_r.mode) begin
          mag2_r[i] <= '0;
        end else if (diff1_r[i][DW-1]) begin
          mag2_r[i] <= DW'(-diff1_r[i]);
        end else begin
          mag2_r[i] <= DW'(diff1_r[i]);
        end
        mag3_r[i] <= mag2_r[i];
        mag4_r[i] <= mag3_r[i];
        sq6_r[i] <= norm5_r[i] * norm5_r[i];
      end
      max3_r <= max3_nxt;
      exp4_r <= exp4_nxt;
      norm5_r <= norm5_nxt;
      norm6_r <= norm5_r;
      norm7_r <= norm6_r;
      sum7_r <= bsk_pkg::S_W'(sq6_r[0]) + bsk_pkg::S_W'(sq6_r[1])
              + bsk_pkg::S_W'(sq6_r[2]);
    end
  end

  assign side_o = side7_r;
  assign norm_o = norm7_r;
  assign sum_o  = sum7_r;

endmodule

/* hdl/bsk_root_div.sv */
// Shared stage chain: square root of the scaled sum and the first division.
// Depends on bsk_pkg.
module bsk_root_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  bsk_pkg::side_t            side_i,
  input  bsk_pkg::norm3_t           norm_i,
  input  logic [bsk_pkg::S_W-1:0]   sum_i,
  output bsk_pkg::side_t            side_o,
  output bsk_pkg::quot3_t           quot_o,
  output logic [bsk_pkg::R_W-1:0]   root_o
);

  localparam int NST = bsk_pkg::ROOT_STEPS;

  bsk_pkg::side_t side_r [NST];
  logic [bsk_pkg::X_W-1:0] x_r [NST];
  logic [bsk_pkg::X_W-1:0] res_r [NST];
  logic [bsk_pkg::S_W-1:0] sum_r [NST];
  logic [2:0][bsk_pkg::S_W-1:0] rem_r [NST];
  bsk_pkg::quot3_t quot_r [NST];

  for (genvar k = 0; k < NST; k++) begin : g_step
    localparam logic [bsk_pkg::X_W-1:0] RBIT = bsk_pkg::X_W'(1) << (62 - 2 * k);
    bsk_pkg::side_t side_c;
    logic [bsk_pkg::X_W-1:0] x_c, res_c, x_nxt, res_nxt, trial;
    logic [bsk_pkg::S_W-1:0] sum_c;
    logic [2:0][bsk_pkg::S_W-1:0] rem_c, rem_nxt;
    bsk_pkg::quot3_t quot_c, quot_nxt;

    if (k == 0) begin : g_first
      assign side_c = side_i;
      assign x_c    = bsk_pkg::X_W'(sum_i) << bsk_pkg::SQRT_PRE;
      assign res_c  = '0;
      assign sum_c  = sum_i;
      assign quot_c = '0;
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_c[i] = bsk_pkg::S_W'(norm_i[i]) << bsk_pkg::DIV1_PRE;
      end
    end else begin : g_next
      assign side_c = side_r[k-1];
      assign x_c    = x_r[k-1];
      assign res_c  = res_r[k-1];
      assign sum_c  = sum_r[k-1];
      assign rem_c  = rem_r[k-1];
      assign quot_c = quot_r[k-1];
    end

    assign trial = res_c + RBIT;

    always_comb begin
      if (x_c >= trial) begin
        x_nxt   = x_c - trial;
        res_nxt = (res_c >> 1) + RBIT;
      end else begin
        x_nxt   = x_c;
        res_nxt = res_c >> 1;
      end
    end

    if (k < bsk_pkg::DIV1_STEPS) begin : g_div
      always_comb begin
        logic [bsk_pkg::S_W:0] dtrial;
        dtrial = '0;
        for (int i = 0; i < 3; i++) begin
          dtrial = {rem_c[i], 1'b0};
          if (dtrial >= {1'b0, sum_c}) begin
            rem_nxt[i]  = bsk_pkg::S_W'(dtrial - {1'b0, sum_c});
            quot_nxt[i] = {quot_c[i][bsk_pkg::Q_W-2:0], 1'b1};
          end else begin
            rem_nxt[i]  = bsk_pkg::S_W'(dtrial);
            quot_nxt[i] = {quot_c[i][bsk_pkg::Q_W-2:0], 1'b0};
          end
        end
      end
    end else begin : g_hold
      assign rem_nxt  = rem_c;
      assign quot_nxt = quot_c;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k] <= '0;
      end else if (en) begin
        side_r[k] <= side_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]    <= x_nxt;
        res_r[k]  <= res_nxt;
        sum_r[k]  <= sum_c;
        rem_r[k]  <= rem_nxt;
        quot_r[k] <= quot_nxt;
      end
    end
  end

  assign side_o = side_r[NST-1];
  assign quot_o = quot_r[NST-1];
  assign root_o = bsk_pkg::R_W'(res_r[NST-1]);

endmodule

/* hdl/bsk_div2.sv */
// Second division stage chain: each quotient over the root, one bit per stage.
// Depends on bsk_pkg.
module bsk_div2 (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  bsk_pkg::side_t          side_i,
  input  bsk_pkg::quot3_t         quot_i,
  input  logic [bsk_pkg::R_W-1:0] root_i,
  output bsk_pkg::side_t          side_o,
  output bsk_pkg::quot3_t         quot_o,
  output bsk_pkg::tq3_t           tq_o
);

  localparam int NST = bsk_pkg::DIV2_STEPS;

  bsk_pkg::side_t side_r [NST];
  logic [bsk_pkg::R_W-1:0] root_r [NST];
  bsk_pkg::quot3_t quot_r [NST];
  logic [2:0][bsk_pkg::R_W-1:0] rem_r [NST];
  bsk_pkg::tq3_t tq_r [NST];

  for (genvar k = 0; k < NST; k++) begin : g_step
    bsk_pkg::side_t side_c;
    logic [bsk_pkg::R_W-1:0] root_c;
    bsk_pkg::quot3_t quot_c;
    logic [2:0][bsk_pkg::R_W-1:0] rem_c, rem_nxt;
    bsk_pkg::tq3_t tq_c, tq_nxt;

    if (k == 0) begin : g_first
      assign side_c = side_i;
      assign root_c = root_i;
      assign quot_c = quot_i;
      assign tq_c   = '0;
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_c[i] = bsk_pkg::R_W'(quot_i[i]) << bsk_pkg::DIV2_PRE;
      end
    end else begin : g_next
      assign side_c = side_r[k-1];
      assign root_c = root_r[k-1];
      assign quot_c = quot_r[k-1];
      assign rem_c  = rem_r[k-1];
      assign tq_c   = tq_r[k-1];
    end

    always_comb begin
      logic [bsk_pkg::R_W:0] dtrial;
      dtrial = '0;
      for (int i = 0; i < 3; i++) begin
        dtrial = {rem_c[i], 1'b0};
        if (dtrial >= {1'b0, root_c}) begin
          rem_nxt[i] = bsk_pkg::R_W'(dtrial - {1'b0, root_c});
          tq_nxt[i]  = {tq_c[i][bsk_pkg::T_W-2:0], 1'b1};
        end else begin
          rem_nxt[i] = bsk_pkg::R_W'(dtrial);
          tq_nxt[i]  = {tq_c[i][bsk_pkg::T_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k] <= '0;
      end else if (en) begin
        side_r[k] <= side_c;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= root_c;
        quot_r[k] <= quot_c;
        rem_r[k]  <= rem_nxt;
        tq_r[k]   <= tq_nxt;
      end
    end
  end

  assign side_o = side_r[NST-1];
  assign quot_o = quot_r[NST-1];
  assign tq_o   = tq_r[NST-1];

endmodule

/* hdl/bsk_back.sv */
// Back pipeline: constant multiply, binary scaling with rounding, clipping and sign.
// Depends on bsk_pkg; its last stage is the output register.
module bsk_back #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  bsk_pkg::side_t                side_i,
  input  bsk_pkg::quot3_t               quot_i,
  input  bsk_pkg::tq3_t                 tq_i,
  output logic                          out_valid,
  output logic signed [COORD_WIDTH-1:0] field_x,
  output logic signed [COORD_WIDTH-1:0] field_y,
  output logic signed [COORD_WIDTH-1:0] field_z,
  output logic                          zero_distance,
  output logic                          saturated
);

  localparam logic [bsk_pkg::X_W-1:0] LIM_POS =
    (bsk_pkg::X_W'(1) << (COORD_WIDTH - 1)) - bsk_pkg::X_W'(1);
  localparam logic [bsk_pkg::X_W-1:0] LIM_NEG = bsk_pkg::X_W'(1) << (COORD_WIDTH - 1);

  bsk_pkg::side_t side_a_r, side_b_r, side_c_r;
  logic [bsk_pkg::P_W-1:0] prod_nxt [3];
  logic [bsk_pkg::P_W-1:0] prod_r [3];
  logic [bsk_pkg::X_W-1:0] mag_nxt [3];
  logic [bsk_pkg::X_W-1:0] mag_r [3];
  logic [COORD_WIDTH-1:0] fld_nxt [3];
  logic [COORD_WIDTH-1:0] fld_r [3];
  logic sat_nxt, sat_r;

  always_comb begin
    logic [bsk_pkg::T_W-1:0] op;
    logic [bsk_pkg::K_W-1:0] kc;
    logic [bsk_pkg::T_W+bsk_pkg::K_W-1:0] pr;
    op = '0;
    kc = '0;
    pr = '0;
    for (int i = 0; i < 3; i++) begin
      if (side_i.mode) begin
        op = tq_i[i];
        kc = bsk_pkg::K_FOUR_PI_INV;
      end else begin
        op = bsk_pkg::T_W'(quot_i[i]);
        kc = bsk_pkg::K_TWO_PI_INV;
      end
      pr = op * kc;
      prod_nxt[i] = bsk_pkg::P_W'(pr);
    end
  end

  always_comb begin
    logic [bsk_pkg::SH_W-1:0] n;
    logic [bsk_pkg::SH_W-1:0] s;
    logic [bsk_pkg::X_W-1:0] lim;
    logic [bsk_pkg::X_W-1:0] half;
    n = bsk_pkg::SH_W'(-side_a_r.sh);
    s = side_a_r.sh;
    lim = '0;
    half = '0;
    for (int i = 0; i < 3; i++) begin
      lim = side_a_r.neg[i] ? LIM_NEG : LIM_POS;
      half = bsk_pkg::X_W'(1) << (n[5:0] - 6'd1);
      if (side_a_r.sh < 0) begin
        if (n > 62) begin
          mag_nxt[i] = '0;
        end else begin
          mag_nxt[i] = (prod_r[i] + half) >> n[5:0];
        end
      end else if (prod_r[i] != '0 && (s >= 63 || prod_r[i] > (lim >> s[5:0]))) begin
        mag_nxt[i] = lim + bsk_pkg::X_W'(1);
      end else begin
        mag_nxt[i] = prod_r[i] << s[5:0];
      end
    end
  end

  always_comb begin
    logic [bsk_pkg::X_W-1:0] lim;
    logic [bsk_pkg::X_W-1:0] clip;
    lim = '0;
    clip = '0;
    sat_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      lim = side_b_r.neg[i] ? LIM_NEG : LIM_POS;
      clip = mag_r[i];
      if (mag_r[i] > lim) begin
        clip = lim;
        if (!side_b_r.zero && (i < 2 || side_b_r.mode)) begin
          sat_nxt = 1'b1;
        end
      end
      if (side_b_r.zero || (i == 2 && !side_b_r.mode)) begin
        fld_nxt[i] = '0;
      end else if (side_b_r.neg[i]) begin
        fld_nxt[i] = COORD_WIDTH'(-clip);
      end else begin
        fld_nxt[i] = COORD_WIDTH'(clip);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_a_r <= '0;
      side_b_r <= '0;
      side_c_r <= '0;
    end else if (en) begin
      side_a_r <= side_i;
      side_b_r <= side_a_r;
      side_c_r <= side_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      mag_r  <= mag_nxt;
      fld_r  <= fld_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign out_valid     = side_c_r.valid;
  assign field_x       = fld_r[0];
  assign field_y       = fld_r[1];
  assign field_z       = fld_r[2];
  assign zero_distance = side_c_r.zero;
  assign saturated     = sat_r;

endmodule

/* hdl/biot_savart_kernel_top.sv */
// Top level of the Biot-Savart kernel: mode register, pipeline sections, stall control.
// Depends on bsk_pkg, bsk_front, bsk_root_div, bsk_div2 and bsk_back.
//
//   Channel  Direction  Handshake           Payload
//   in       input      in_valid/in_stall   eval_x/y/z, source_x/y/z
//   out      output     out_valid/out_stall field_x/y/z, zero_distance, saturated
//   cfg      input      cfg_valid/cfg_ready cfg_data (dimension mode)
//
// One beat enters per cycle while in_stall is low; results leave in the order the beats were taken.
// Most registers lie in the 32-step square root chain and the 32-step second divider.
// A stalled output beat freezes the whole pipeline and raises in_stall until it is taken.
// Reset is synchronous and empties the pipeline; the mode comes up in 3D.
module biot_savart_kernel_top #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_eval_x,
  input  logic signed [COORD_WIDTH-1:0] in_eval_y,
  input  logic signed [COORD_WIDTH-1:0] in_eval_z,
  input  logic signed [COORD_WIDTH-1:0] in_source_x,
  input  logic signed [COORD_WIDTH-1:0] in_source_y,
  input  logic signed [COORD_WIDTH-1:0] in_source_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] out_field_x,
  output logic signed [COORD_WIDTH-1:0] out_field_y,
  output logic signed [COORD_WIDTH-1:0] out_field_z,
  output logic                          out_zero_distance,
  output logic                          out_saturated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data
);

  logic en;
  logic mode_r;
  bsk_pkg::side_t side_f, side_r1, side_d2;
  bsk_pkg::norm3_t norm_f;
  logic [bsk_pkg::S_W-1:0] sum_f;
  bsk_pkg::quot3_t quot_r1, quot_d2;
  logic [bsk_pkg::R_W-1:0] root_r1;
  bsk_pkg::tq3_t tq_d2;

  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  bsk_front #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_valid(in_valid),
    .mode    (mode_r),
    .eval_x  (in_eval_x),
    .eval_y  (in_eval_y),
    .eval_z  (in_eval_z),
    .source_x(in_source_x),
    .source_y(in_source_y),
    .source_z(in_source_z),
    .side_o  (side_f),
    .norm_o  (norm_f),
    .sum_o   (sum_f)
  );

  bsk_root_div u_root_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .side_i(side_f),
    .norm_i(norm_f),
    .sum_i (sum_f),
    .side_o(side_r1),
    .quot_o(quot_r1),
    .root_o(root_r1)
  );

  bsk_div2 u_div2 (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .side_i(side_r1),
    .quot_i(quot_r1),
    .root_i(root_r1),
    .side_o(side_d2),
    .quot_o(quot_d2),
    .tq_o  (tq_d2)
  );

  bsk_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .side_i       (side_d2),
    .quot_i       (quot_d2),
    .tq_i         (tq_d2),
    .out_valid    (out_valid),
    .field_x      (out_field_x),
    .field_y      (out_field_y),
    .field_z      (out_field_z),
    .zero_distance(out_zero_distance),
    .saturated    (out_saturated)
  );

`ifndef SYNTHESIS
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled output beat");

  a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_distance) |->
      (out_field_x == '0 && out_field_y == '0 && out_field_z == '0 && !out_saturated))
    else $error("zero distance beat carries nonzero data");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_field_x) && $stable(out_saturated)))
    else $error("pipeline advanced under output stall");
`endif

endmodule

/* tb/biot_savart_kernel_top_test.sv */
// Self-checking testbench of the Biot-Savart kernel top level, 2D and 3D modes.
// Instantiates biot_savart_kernel_top and uses bsk_pkg; predicts each beat in fixed point here.
module biot_savart_kernel_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 32;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam logic MODE_2D = 1'b0;
  localparam logic MODE_3D = 1'b1;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t fx;
    coord_t fy;
    coord_t fz;
    logic   zero_dist;
    logic   sat;
  } field_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_eval_x = '0, in_eval_y = '0, in_eval_z = '0;
  coord_t in_source_x = '0, in_source_y = '0, in_source_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  coord_t out_field_x, out_field_y, out_field_z;
  logic out_zero_distance, out_saturated;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  field_t expected_fields[$];
  logic   mode_copy = MODE_3D;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     fail_count = 0;
  int     results_seen = 0;
  int     zero_seen = 0;
  int     sat_seen = 0;
  int     cycle_count = 0;

  biot_savart_kernel_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_eval_x(in_eval_x), .in_eval_y(in_eval_y), .in_eval_z(in_eval_z),
    .in_source_x(in_source_x), .in_source_y(in_source_y), .in_source_z(in_source_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_field_x(out_field_x), .out_field_y(out_field_y), .out_field_z(out_field_z),
    .out_zero_distance(out_zero_distance), .out_saturated(out_saturated),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Returns the clip flag above the signed component.
  function automatic logic [CW:0] scale_clip(longint unsigned p, int sh, bit neg);
    longint unsigned limit;
    longint unsigned mag;
    logic clipped;
    limit = neg ? (64'd1 << (CW - 1)) : ((64'd1 << (CW - 1)) - 1);
    clipped = 1'b0;
    if (sh < 0) begin
      mag = (-sh > 62) ? 64'd0 : ((p + (64'd1 << (-sh - 1))) >> (-sh));
    end else if (p != 0 && (sh >= 63 || p > (limit >> sh))) begin
      mag = limit + 1;
    end else begin
      mag = p << sh;
    end
    if (mag > limit) begin
      mag = limit;
      clipped = 1'b1;
    end
    if (neg) mag = -mag;
    return {clipped, mag[CW-1:0]};
  endfunction

  function automatic field_t kernel_field(coord_t ev[3], coord_t src[3], logic mode);
    longint d;
    longint unsigned mg[3];
    bit ng[3];
    longint unsigned m, s_sum, q, t, r;
    int axes, len, ex, sh, i;
    logic [CW:0] comp[3];
    field_t res;
    axes = (mode == MODE_3D) ? 3 : 2;
    m = 0;
    s_sum = 0;
    res = '{default: '0};
    comp[0] = '0; comp[1] = '0; comp[2] = '0;
    for (i = 0; i < 3; i++) begin
      mg[i] = 0;
      ng[i] = 0;
    end
    for (i = 0; i < axes; i++) begin
      d = longint'(ev[i]) - longint'(src[i]);
      ng[i] = d < 0;
      mg[i] = ng[i] ? -d : d;
      if (mg[i] > m) m = mg[i];
    end
    if (m == 0) begin
      res.zero_dist = 1'b1;
      return res;
    end
    len = 0;
    while (len < 63 && (m >> len) != 0) len++;
    ex = len - bsk_pkg::NORM_BITS;
    for (i = 0; i < axes; i++) begin
      mg[i] = (ex > 0) ? (mg[i] >> ex) : (mg[i] << (-ex));
      s_sum += mg[i] * mg[i];
    end
    if (axes == 2) begin
      sh = 2 * 16 - ex - 70;
      for (i = 0; i < 2; i++) begin
        q = (mg[i] << 38) / s_sum;
        comp[i] = scale_clip(q * 64'd683565276, sh, ng[i]);
      end
    end else begin
      r = int_sqrt(s_sum << 14);
      sh = 3 * 16 - 2 * ex - 109;
      for (i = 0; i < 3; i++) begin
        q = (mg[i] << 38) / s_sum;
        t = (q << 46) / r;
        comp[i] = scale_clip(t * 64'd341782638, sh, ng[i]);
      end
    end
    res.fx = comp[0][CW-1:0];
    res.fy = comp[1][CW-1:0];
    res.fz = comp[2][CW-1:0];
    res.sat = comp[0][CW] | comp[1][CW] | comp[2][CW];
    return res;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("%0t: timeout with %0d beats outstanding", $time, expected_fields.size());
      $display("biot_savart_kernel_top verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    field_t exp_f;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_fields.size() == 0) begin
        $display("%0t: unexpected result beat, actual %h %h %h %b %b", $time, out_field_x,
                 out_field_y, out_field_z, out_zero_distance, out_saturated);
        fail_count++;
      end else begin
        exp_f = expected_fields.pop_front();
        results_seen++;
        if (exp_f.zero_dist) zero_seen++;
        if (exp_f.sat) sat_seen++;
        if (out_field_x !== exp_f.fx)
          $display("%0t: field_x expected %h actual %h", $time, exp_f.fx, out_field_x);
        if (out_field_y !== exp_f.fy)
          $display("%0t: field_y expected %h actual %h", $time, exp_f.fy, out_field_y);
        if (out_field_z !== exp_f.fz)
          $display("%0t: field_z expected %h actual %h", $time, exp_f.fz, out_field_z);
        if (out_zero_distance !== exp_f.zero_dist)
          $display("%0t: zero_distance expected %b actual %b", $time, exp_f.zero_dist,
                   out_zero_distance);
        if (out_saturated !== exp_f.sat)
          $display("%0t: saturated expected %b actual %b", $time, exp_f.sat, out_saturated);
        if (out_field_x !== exp_f.fx || out_field_y !== exp_f.fy || out_field_z !== exp_f.fz
            || out_zero_distance !== exp_f.zero_dist || out_saturated !== exp_f.sat)
          fail_count++;
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  task automatic send_pair(coord_t ev[3], coord_t src[3]);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_eval_x <= ev[0];
    in_eval_y <= ev[1];
    in_eval_z <= ev[2];
    in_source_x <= src[0];
    in_source_y <= src[1];
    in_source_z <= src[2];
    do @(posedge clk); while (in_stall);
    expected_fields.push_back(kernel_field(ev, src, mode_copy));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_mode(logic mode);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_copy = mode;
  endtask

  task automatic test_directed();
    coord_t mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    send_pair('{0, 0, 0}, '{0, 0, 0});
    send_pair('{mx, mn, mx}, '{mx, mn, mx});
    send_pair('{mx, 0, 0}, '{mn, 0, 0});
    send_pair('{mn, 0, 0}, '{mx, 0, 0});
    send_pair('{mx, mx, mx}, '{mn, mn, mn});
    send_pair('{mn, mx, mn}, '{mx, mn, mx});
    send_pair('{0, 0, 5}, '{0, 0, -3});
    send_pair('{1, 0, 0}, '{0, 0, 0});
    send_pair('{0, -1, 0}, '{0, 0, 0});
    send_pair('{32'h10000, 32'h10000, 32'h10000}, '{0, 0, 0});
    send_pair('{32'h1000000, 0, 0}, '{0, 0, 0});
    send_pair('{-1, -1, -1}, '{mx, mx, mx});
  endtask

  task automatic test_random(int count);
    coord_t ev[3], src[3];
    int kind;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 99);
      for (int i = 0; i < 3; i++) begin
        src[i] = $urandom;
        if (kind < 10) begin
          ev[i] = src[i];
        end else if (kind < 30) begin
          ev[i] = $urandom;
        end else if ($urandom_range(0, 4) == 0) begin
          ev[i] = src[i];
        end else begin
          ev[i] = src[i] + ($urandom_range(0, 1) ? -1 : 1) *
                  $signed({1'b0, 31'($urandom >> $urandom_range(1, 31))});
        end
      end
      send_pair(ev, src);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    wait_drained();
    write_mode(MODE_2D);
    test_directed();
    wait_drained();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 87 : 0;
      recv_idle_pct = (ph == 0) ? 87 : (ph == 1) ? 37 : 0;
      write_mode(MODE_3D);
      test_random(170);
      wait_drained();
      write_mode(MODE_2D);
      test_random(170);
      wait_drained();
    end
    write_mode(MODE_3D);
    wait_drained();
    $display("Checked %0d result beats in 2D and 3D modes under three stall patterns.",
             results_seen);
    $display("Coinciding points: %0d, clipped results: %0d.", zero_seen, sat_seen);
    if (fail_count == 0) begin
      $display("biot_savart_kernel_top verification clean");
    end else begin
      $display("biot_savart_kernel_top verification failed");
    end
    $finish;
  end
endmodule
